FILE: hw/rtl/sorted_priority_queue_assert.svh
// Assertion macros for the queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Checked on every rising edge outside reset.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

  // Fixed field widths of the request and response.
  localparam int REQ_BITS       = 2;
  localparam int POS_BITS       = 6;
  localparam int STATUS_BITS    = 2;
  localparam int COUNT_OUT_BITS = 7;

  // Request codes.
  localparam logic [REQ_BITS-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_POP    = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_PEEK   = 2'd2;

  // Status codes.
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic pop;
    logic rd_load;
    logic rd_shift;
  } spq_cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/spq_req_if.sv
`default_nettype none

interface spq_req_if #(
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 16
);
  logic                               valid;
  logic                               ready;
  logic [spq_pkg::REQ_BITS-1:0]       req_type;
  logic signed [KEY_BITS-1:0]         key;
  logic [TAG_BITS-1:0]                tag;
  logic [spq_pkg::POS_BITS-1:0]       position;

  modport source (output valid, req_type, key, tag, position, input ready);
  modport sink   (input valid, req_type, key, tag, position, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/spq_rsp_if.sv
`default_nettype none

interface spq_rsp_if #(
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 16
);
  logic                               valid;
  logic                               ready;
  logic                               out_valid;
  logic signed [KEY_BITS-1:0]         out_key;
  logic [TAG_BITS-1:0]                out_tag;
  logic [spq_pkg::STATUS_BITS-1:0]    status;
  logic [spq_pkg::COUNT_OUT_BITS-1:0] entry_count;

  modport source (output valid, out_valid, out_key, out_tag, status, entry_count,
                  input ready);
  modport sink   (input valid, out_valid, out_key, out_tag, status, entry_count,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/spq_cell.sv
`default_nettype none

// One position of the sorted list, plus one stage of the read-out chain.
module spq_cell #(
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 16
) (
  input  wire                         clk,
  input  wire spq_pkg::spq_cell_ctrl_t ctrl,
  input  wire                         occ,
  input  wire signed [KEY_BITS-1:0]   new_key,
  input  wire [TAG_BITS-1:0]          new_tag,
  input  wire                         prev_ge,
  input  wire signed [KEY_BITS-1:0]   prev_key,
  input  wire [TAG_BITS-1:0]          prev_tag,
  input  wire signed [KEY_BITS-1:0]   next_key,
  input  wire [TAG_BITS-1:0]          next_tag,
  input  wire signed [KEY_BITS-1:0]   next_rd_key,
  input  wire [TAG_BITS-1:0]          next_rd_tag,
  output logic                        ge,
  output logic signed [KEY_BITS-1:0]  key,
  output logic [TAG_BITS-1:0]         tag,
  output logic signed [KEY_BITS-1:0]  rd_key,
  output logic [TAG_BITS-1:0]         rd_tag
);

  // A held key at least as large as the new one stays where it is.
  assign ge = occ && (key >= new_key);

  // Entry register: keep, take the new entry, or shift by one place.
  always_ff @(posedge clk) begin
    if (ctrl.ins && !ge) begin
      if (prev_ge) begin
        key <= new_key;
        tag <= new_tag;
      end else begin
        key <= prev_key;
        tag <= prev_tag;
      end
    end else if (ctrl.pop) begin
      key <= next_key;
      tag <= next_tag;
    end
  end

  // Read-out chain: a snapshot of the list that moves towards the head.
  always_ff @(posedge clk) begin
    if (ctrl.rd_load) begin
      rd_key <= key;
      rd_tag <= tag;
    end else if (ctrl.rd_shift) begin
      rd_key <= next_rd_key;
      rd_tag <= next_rd_tag;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_priority_queue.sv
// Inserts and pops change the list and register the response as they are taken.
// A peek at position p loads the read-out chain, shifts it p places, then answers.
// Requests are refused during a peek or a held response; otherwise one a cycle is taken.
// Synchronous reset clears the entry count, the controller and the response valid flag.
// The entry registers are not reset and need no clearing pass.
`default_nettype none

module sorted_priority_queue #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 16
) (
  input  wire       clk,
  input  wire       rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > spq_pkg::POS_BITS) ? CW : spq_pkg::POS_BITS;

  typedef enum logic {
    S_IDLE,
    S_PEEK
  } state_t;

  state_t                          state;
  logic [CW-1:0]                   count;
  logic [spq_pkg::POS_BITS-1:0]    peek_cnt;

  logic                            rsp_v;
  logic                            rsp_out_valid;
  logic signed [KEY_BITS-1:0]      rsp_key;
  logic [TAG_BITS-1:0]             rsp_tag;
  logic [spq_pkg::STATUS_BITS-1:0] rsp_status;
  logic [spq_pkg::COUNT_OUT_BITS-1:0] rsp_count;

  logic                            accept;
  logic                            full;
  logic                            empty;
  logic                            pos_ok;
  spq_pkg::spq_cell_ctrl_t         ctrl;

  logic                            occ    [DEPTH];
  logic                            ge     [DEPTH];
  logic signed [KEY_BITS-1:0]      c_key  [DEPTH];
  logic [TAG_BITS-1:0]             c_tag  [DEPTH];
  logic signed [KEY_BITS-1:0]      r_key  [DEPTH];
  logic [TAG_BITS-1:0]             r_tag  [DEPTH];

  // Handshake: out of reset, a free or draining response register, and no peek under way.
  assign req.ready = !rst && (state == S_IDLE) && (!rsp_v || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign rsp.valid       = rsp_v;
  assign rsp.out_valid   = rsp_out_valid;
  assign rsp.out_key     = rsp_key;
  assign rsp.out_tag     = rsp_tag;
  assign rsp.status      = rsp_status;
  assign rsp.entry_count = rsp_count;

  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign pos_ok = (MW'(req.position) < MW'(count)) && (MW'(req.position) < MW'(DEPTH));

  // Commands for the cell row.
  always_comb begin
    ctrl          = '0;
    ctrl.rd_shift = (state == S_PEEK) && (peek_cnt != '0);
    if (accept) begin
      unique case (req.req_type)
        spq_pkg::REQ_INSERT: ctrl.ins     = !full;
        spq_pkg::REQ_POP:    ctrl.pop     = !empty;
        spq_pkg::REQ_PEEK:   ctrl.rd_load = pos_ok;
        default:             ctrl         = '0;
      endcase
    end
  end

  // The row of cells; the head also takes from the request, the tail from itself.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (count > CW'(i));

    if (i == 0) begin : g_head
      spq_cell #(.KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS)) u_cell (
        .clk(clk), .ctrl(ctrl), .occ(occ[i]), .new_key(req.key), .new_tag(req.tag),
        .prev_ge(1'b1), .prev_key(req.key), .prev_tag(req.tag),
        .next_key(c_key[i+1]), .next_tag(c_tag[i+1]),
        .next_rd_key(r_key[i+1]), .next_rd_tag(r_tag[i+1]),
        .ge(ge[i]), .key(c_key[i]), .tag(c_tag[i]), .rd_key(r_key[i]), .rd_tag(r_tag[i])
      );
    end else if (i == DEPTH - 1) begin : g_tail
      spq_cell #(.KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS)) u_cell (
        .clk(clk), .ctrl(ctrl), .occ(occ[i]), .new_key(req.key), .new_tag(req.tag),
        .prev_ge(ge[i-1]), .prev_key(c_key[i-1]), .prev_tag(c_tag[i-1]),
        .next_key(c_key[i]), .next_tag(c_tag[i]),
        .next_rd_key(r_key[i]), .next_rd_tag(r_tag[i]),
        .ge(ge[i]), .key(c_key[i]), .tag(c_tag[i]), .rd_key(r_key[i]), .rd_tag(r_tag[i])
      );
    end else begin : g_mid
      spq_cell #(.KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS)) u_cell (
        .clk(clk), .ctrl(ctrl), .occ(occ[i]), .new_key(req.key), .new_tag(req.tag),
        .prev_ge(ge[i-1]), .prev_key(c_key[i-1]), .prev_tag(c_tag[i-1]),
        .next_key(c_key[i+1]), .next_tag(c_tag[i+1]),
        .next_rd_key(r_key[i+1]), .next_rd_tag(r_tag[i+1]),
        .ge(ge[i]), .key(c_key[i]), .tag(c_tag[i]), .rd_key(r_key[i]), .rd_tag(r_tag[i])
      );
    end
  end

  // Controller, entry count and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rsp_v <= 1'b0;
    end else begin
      if (rsp_v && rsp.ready) begin
        rsp_v <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rsp_out_valid <= 1'b0;
            rsp_key       <= '0;
            rsp_tag       <= '0;
            rsp_status    <= spq_pkg::ST_OK;
            rsp_count     <= spq_pkg::COUNT_OUT_BITS'(count);
            rsp_v         <= 1'b1;
            unique case (req.req_type)
              spq_pkg::REQ_INSERT: begin
                if (full) begin
                  rsp_status <= spq_pkg::ST_FULL;
                end else begin
                  count     <= count + 1'b1;
                  rsp_count <= spq_pkg::COUNT_OUT_BITS'(count + 1'b1);
                end
              end
              spq_pkg::REQ_POP: begin
                if (empty) begin
                  rsp_status <= spq_pkg::ST_EMPTY;
                end else begin
                  count         <= count - 1'b1;
                  rsp_count     <= spq_pkg::COUNT_OUT_BITS'(count - 1'b1);
                  rsp_out_valid <= 1'b1;
                  rsp_key       <= c_key[0];
                  rsp_tag       <= c_tag[0];
                end
              end
              spq_pkg::REQ_PEEK: begin
                if (!pos_ok) begin
                  rsp_status <= spq_pkg::ST_EMPTY;
                end else begin
                  // The answer waits until the read-out chain has moved.
                  rsp_v    <= 1'b0;
                  peek_cnt <= req.position;
                  state    <= S_PEEK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_PEEK: begin
          if (peek_cnt == '0) begin
            rsp_v         <= 1'b1;
            rsp_out_valid <= 1'b1;
            rsp_key       <= r_key[0];
            rsp_tag       <= r_tag[0];
            rsp_status    <= spq_pkg::ST_OK;
            rsp_count     <= spq_pkg::COUNT_OUT_BITS'(count);
            state         <= S_IDLE;
          end else begin
            peek_cnt <= peek_cnt - 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the controller and the list order.
`include "sorted_priority_queue_assert.svh"

  `SPQ_ASSERT(a_count_bound, (count <= CW'(DEPTH)), "entry count beyond depth")
  `SPQ_ASSERT_ALWAYS(a_peek_blocks, (state == S_PEEK) |-> !req.ready, "request taken during peek")
  `SPQ_ASSERT(a_insert_count, (accept && req.req_type == spq_pkg::REQ_INSERT && !full) |=> (count == $past(count) + 1'b1), "insert did not grow count")
  `SPQ_ASSERT(a_pop_result, (accept && req.req_type == spq_pkg::REQ_POP && !empty) |=> (rsp.valid && rsp.out_valid), "pop gave no entry")
  `SPQ_ASSERT(a_head_order, (count >= CW'(2)) |-> (c_key[0] >= c_key[1]), "head out of order")

endmodule

`default_nettype wire

FILE: bench/spq_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the sorted list and checks
// each response against the one predicted for the oldest open request.
module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 16
) (
  input  wire clk,
  input  wire rst,
  spq_req_if  req,
  spq_rsp_if  rsp,
  output int  errors,
  output int  pending,
  output int  pops_returned,
  output int  full_refusals,
  output int  empty_flags,
  output int  peak_fill
);

  typedef struct packed {
    logic                         out_valid;
    logic signed [KEY_BITS-1:0]   out_key;
    logic [TAG_BITS-1:0]          out_tag;
    logic [STATUS_BITS-1:0]       status;
    logic [COUNT_OUT_BITS-1:0]    entry_count;
  } queue_result_t;

  // Predicted list, largest key at index zero.
  logic signed [KEY_BITS-1:0] held_key [DEPTH];
  logic [TAG_BITS-1:0]        held_tag [DEPTH];
  int                         held;

  queue_result_t awaited [$];
  int err_tally, pop_tally, full_tally, empty_tally, peak_tally;

  // Applies one request to the predicted list and returns its response.
  function automatic queue_result_t serve_request(
    input logic [REQ_BITS-1:0]      kind,
    input logic signed [KEY_BITS-1:0] k,
    input logic [TAG_BITS-1:0]      t,
    input logic [POS_BITS-1:0]      p
  );
    queue_result_t res;
    int slot;
    res = '0;
    case (kind)
      REQ_INSERT: begin
        if (held >= DEPTH) begin
          res.status = ST_FULL;
          full_tally++;
        end else begin
          // A new entry goes behind every key greater than or equal to it.
          slot = 0;
          while (slot < held && held_key[slot] >= k) slot++;
          for (int i = held; i > slot; i--) begin
            held_key[i] = held_key[i-1];
            held_tag[i] = held_tag[i-1];
          end
          held_key[slot] = k;
          held_tag[slot] = t;
          held++;
          if (held > peak_tally) peak_tally = held;
        end
      end
      REQ_POP: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
          empty_tally++;
        end else begin
          res.out_valid = 1'b1;
          res.out_key   = held_key[0];
          res.out_tag   = held_tag[0];
          for (int i = 0; i + 1 < held; i++) begin
            held_key[i] = held_key[i+1];
            held_tag[i] = held_tag[i+1];
          end
          held--;
          pop_tally++;
        end
      end
      REQ_PEEK: begin
        if (int'(p) >= held) begin
          res.status = ST_EMPTY;
          empty_tally++;
        end else begin
          res.out_valid = 1'b1;
          res.out_key   = held_key[p];
          res.out_tag   = held_tag[p];
        end
      end
      default: begin
        // The unused code leaves the list alone and answers plainly.
      end
    endcase
    res.entry_count = COUNT_OUT_BITS'(held);
    return res;
  endfunction

  // Compares the response on the channel with the oldest prediction.
  task automatic check_response();
    queue_result_t want;
    if (awaited.size() == 0) begin
      $error("response with no request outstanding");
      err_tally++;
      return;
    end
    want = awaited.pop_front();
    if (rsp.out_valid !== want.out_valid) begin
      $error("out_valid: expected %0d, got %0d", want.out_valid, rsp.out_valid);
      err_tally++;
    end
    if (rsp.out_key !== want.out_key) begin
      $error("out_key: expected %0d, got %0d", want.out_key, rsp.out_key);
      err_tally++;
    end
    if (rsp.out_tag !== want.out_tag) begin
      $error("out_tag: expected 0x%0h, got 0x%0h", want.out_tag, rsp.out_tag);
      err_tally++;
    end
    if (rsp.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, rsp.status);
      err_tally++;
    end
    if (rsp.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, rsp.entry_count);
      err_tally++;
    end
  endtask

  // Responses are checked before the request of the same edge is predicted,
  // since a response can never belong to a request taken on that edge.
  always @(posedge clk) begin
    if (rst) begin
      held = 0;
      awaited.delete();
    end else begin
      if (rsp.valid && rsp.ready) check_response();
      if (req.valid && req.ready)
        awaited.push_back(serve_request(req.req_type, req.key, req.tag, req.position));
    end
    errors        <= err_tally;
    pending       <= awaited.size();
    pops_returned <= pop_tally;
    full_refusals <= full_tally;
    empty_flags   <= empty_tally;
    peak_fill     <= peak_tally;
  end

  initial begin
    held        = 0;
    err_tally   = 0;
    pop_tally   = 0;
    full_tally  = 0;
    empty_tally = 0;
    peak_tally  = 0;
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = 64;
  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 100;
  localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit want_hold = 1'b0;
  int sent = 0;

  int errors, pending, pops_returned, full_refusals, empty_flags, peak_fill;

  spq_req_if req ();
  spq_rsp_if rsp ();

  sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  spq_checker #(.DEPTH(QUEUE_DEPTH)) result_check (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .rsp           (rsp),
    .errors        (errors),
    .pending       (pending),
    .pops_returned (pops_returned),
    .full_refusals (full_refusals),
    .empty_flags   (empty_flags),
    .peak_fill     (peak_fill)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (want_hold) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        want_hold = 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= stall_pct);
        @(posedge clk);
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
      else quiet++;
    end
    $display("sorted_priority_queue test failed");
    $finish;
  end

  // Offers one request, with random idle cycles first, and returns on the
  // edge at which it is taken. Valid is left high for the next request.
  task automatic issue(
    input logic [REQ_BITS-1:0]  kind,
    input logic signed [15:0]   k,
    input logic [15:0]          t,
    input logic [POS_BITS-1:0]  p
  );
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req.valid    <= 1'b1;
    req.req_type <= kind;
    req.key      <= k;
    req.tag      <= t;
    req.position <= p;
    do @(posedge clk); while (!req.ready);
    sent++;
  endtask

  // Stops offering and waits until every response has come back.
  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Keys lean towards a narrow band so that ties are frequent.
  function automatic logic signed [15:0] pick_key();
    case ($urandom_range(3))
      0: pick_key = 16'($urandom);
      1: begin
        case ($urandom_range(3))
          0: pick_key = 16'sh7fff;
          1: pick_key = -16'sh8000;
          2: pick_key = 16'sd0;
          default: pick_key = -16'sd1;
        endcase
      end
      default: pick_key = 16'($urandom_range(15)) - 16'sd8;
    endcase
  endfunction

  // Random requests; insert_pct steers the list towards full or empty.
  task automatic random_run(input int n, input int insert_pct);
    int r;
    logic [REQ_BITS-1:0] kind;
    logic [POS_BITS-1:0] p;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if ($urandom_range(99) < insert_pct) kind = REQ_INSERT;
      else if (r < 60) kind = REQ_POP;
      else if (r < 95) kind = REQ_PEEK;
      else kind = REQ_UNUSED;
      p = $urandom_range(1) ? POS_BITS'($urandom_range(63)) : POS_BITS'($urandom_range(7));
      issue(kind, pick_key(), 16'($urandom), p);
    end
    wait_drained();
  endtask

  initial begin
    req.valid    <= 1'b0;
    req.req_type <= REQ_INSERT;
    req.key      <= '0;
    req.tag      <= '0;
    req.position <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list, extremes, ties and the range edges of a peek.
    issue(REQ_POP, 16'sd0, 16'h0000, 6'd0);
    issue(REQ_PEEK, 16'sd0, 16'h0000, 6'd0);
    issue(REQ_UNUSED, -16'sd1, 16'hffff, 6'd63);
    issue(REQ_INSERT, 16'sh7fff, 16'hffff, 6'd0);
    issue(REQ_INSERT, -16'sh8000, 16'h0000, 6'd0);
    issue(REQ_INSERT, 16'sd5, 16'h0001, 6'd0);
    issue(REQ_INSERT, 16'sd5, 16'h0002, 6'd0);
    issue(REQ_INSERT, 16'sd5, 16'h0003, 6'd0);
    issue(REQ_INSERT, -16'sd1, 16'h8000, 6'd0);
    issue(REQ_PEEK, 16'sd0, 16'h0000, 6'd0);
    issue(REQ_PEEK, 16'sd0, 16'h0000, 6'd5);
    issue(REQ_PEEK, 16'sd0, 16'h0000, 6'd6);
    issue(REQ_PEEK, 16'sd0, 16'h0000, 6'd63);
    for (int i = 0; i < 6; i++) issue(REQ_POP, 16'sd0, 16'h0000, 6'd0);
    issue(REQ_POP, 16'sd0, 16'h0000, 6'd0);
    issue(REQ_PEEK, 16'sd0, 16'h0000, 6'd0);
    wait_drained();

    // Random phases with different amounts of idling on each side.
    random_run(60, 75);
    send_idle_pct = 68;
    random_run(60, 35);
    send_idle_pct = 0;
    stall_pct = 68;
    random_run(60, 65);
    send_idle_pct = 20;
    stall_pct = 20;
    random_run(60, 30);

    // Long hold-off on the response side while inserts keep coming, which
    // backs the block up and later fills the list to its limit.
    send_idle_pct = 0;
    stall_pct = 0;
    want_hold = 1'b1;
    for (int i = 0; i < 80; i++) issue(REQ_INSERT, pick_key(), 16'($urandom), 6'd0);
    wait_drained();

    send_idle_pct = 20;
    stall_pct = 20;
    random_run(40, 25);
    send_idle_pct = 0;
    stall_pct = 0;
    random_run(40, 50);

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests: %0d entries popped, %0d inserts refused when full,",
             sent, pops_returned, full_refusals);
    $display("%0d pops or peeks flagged as empty or out of range; list held up to %0d.",
             empty_flags, peak_fill);
    if (errors == 0 && pending == 0) begin
      $display("sorted_priority_queue test passed");
    end else begin
      $display("sorted_priority_queue test failed");
    end
    $finish;
  end

endmodule
